// ----- src/qsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_pkg
// Types, character constants and helpers shared by the quoted string
// unescaper modules.
// ----------------------------------------------------------------------------
package qsu_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R_LOW     = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_R_UP      = 8'h52;
  localparam logic [7:0] CH_DEL       = 8'h7F;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_TAB     = 8'h09;

  localparam logic [7:0] QUOTE_RESET  = 8'h22;

  // configuration register indexes
  localparam logic REG_QUOTE_CHAR = 1'b0;
  localparam logic REG_RAW_MODE   = 1'b1;

  typedef enum logic [3:0] {
    PH_NORMAL = 4'b0001,
    PH_ESCAPE = 4'b0010,
    PH_HEX1   = 4'b0100,
    PH_HEX2   = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_RAW_PREFIX = 3'd2,
    ST_DELIM      = 3'd3,
    ST_CONTROL    = 3'd4,
    ST_BAD_ESCAPE = 3'd5,
    ST_BAD_HEX    = 3'd6,
    ST_INCOMPLETE = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] quote_char;
    logic       raw_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0] position;
    phase_e     phase;
    logic [3:0] high_nibble;
    logic       high_ok;
    status_e    hdr_err;
    status_e    body_err;
  } lit_state_t;

  localparam lit_state_t LIT_STATE_RESET = '{
    position:    2'd0,
    phase:       PH_NORMAL,
    high_nibble: 4'd0,
    high_ok:     1'b0,
    hdr_err:     ST_OK,
    body_err:    ST_OK
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic    keep;
    result_t res;
  } step_out_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // value of one hex digit, either case; zero when not a digit
  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

// ----- src/qsu_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_core
// Literal state registers and the per-character decode step: header checks,
// escape decoding and end status.
// ----------------------------------------------------------------------------
module qsu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  qsu_pkg::cfg_t       cfg_i,
  input  logic [7:0]          ch_i,
  input  logic                last_i,
  output qsu_pkg::step_out_t  step_o
);

  qsu_pkg::lit_state_t st_q, st_d;
  qsu_pkg::hex_t       hx;
  logic [1:0]          hdr_len;

  always_comb begin
    st_d    = st_q;
    step_o  = '0;
    step_o.res.status = qsu_pkg::ST_OK;
    hdr_len = cfg_i.raw_mode ? 2'd2 : 2'd1;
    hx      = qsu_pkg::hex_digit(ch_i);

    if (last_i) begin
      step_o.keep       = 1'b1;
      step_o.res.is_end = 1'b1;
      if (st_q.position < hdr_len) begin
        step_o.res.status = qsu_pkg::ST_SHORT;
      end else if (st_q.hdr_err != qsu_pkg::ST_OK) begin
        step_o.res.status = st_q.hdr_err;
      end else if (ch_i != cfg_i.quote_char) begin
        step_o.res.status = qsu_pkg::ST_DELIM;
      end else if (st_q.body_err != qsu_pkg::ST_OK) begin
        step_o.res.status = st_q.body_err;
      end else if (st_q.phase != qsu_pkg::PH_NORMAL) begin
        step_o.res.status = qsu_pkg::ST_INCOMPLETE;
      end
      st_d = qsu_pkg::LIT_STATE_RESET;
    end else begin
      if (st_q.position != 2'd3) begin
        st_d.position = st_q.position + 2'd1;
      end
      if (st_q.position < hdr_len) begin
        // prefix / opening quote
        if (cfg_i.raw_mode && st_q.position == 2'd0) begin
          if (ch_i != qsu_pkg::CH_R_LOW && ch_i != qsu_pkg::CH_R_UP &&
              st_q.hdr_err == qsu_pkg::ST_OK) begin
            st_d.hdr_err = qsu_pkg::ST_RAW_PREFIX;
          end
        end else if (ch_i != cfg_i.quote_char && st_q.hdr_err == qsu_pkg::ST_OK) begin
          st_d.hdr_err = qsu_pkg::ST_DELIM;
        end
      end else if (st_q.hdr_err == qsu_pkg::ST_OK && st_q.body_err == qsu_pkg::ST_OK) begin
        case (st_q.phase)
          qsu_pkg::PH_NORMAL: begin
            if (ch_i < qsu_pkg::CH_SPACE || ch_i == qsu_pkg::CH_DEL) begin
              st_d.body_err = qsu_pkg::ST_CONTROL;
            end else if (!cfg_i.raw_mode && ch_i == qsu_pkg::CH_BACKSLASH) begin
              st_d.phase = qsu_pkg::PH_ESCAPE;
            end else begin
              step_o.keep         = 1'b1;
              step_o.res.out_byte = ch_i;
            end
          end
          qsu_pkg::PH_ESCAPE: begin
            // escape letters win over a quote char that equals one of them
            if (ch_i == qsu_pkg::CH_BACKSLASH) begin
              step_o.keep         = 1'b1;
              step_o.res.out_byte = qsu_pkg::CH_BACKSLASH;
            end else if (ch_i == qsu_pkg::CH_N) begin
              step_o.keep         = 1'b1;
              step_o.res.out_byte = qsu_pkg::BYTE_LF;
            end else if (ch_i == qsu_pkg::CH_R_LOW) begin
              step_o.keep         = 1'b1;
              step_o.res.out_byte = qsu_pkg::BYTE_CR;
            end else if (ch_i == qsu_pkg::CH_T) begin
              step_o.keep         = 1'b1;
              step_o.res.out_byte = qsu_pkg::BYTE_TAB;
            end else if (ch_i == qsu_pkg::CH_X) begin
              st_d.phase = qsu_pkg::PH_HEX1;
            end else if (ch_i == cfg_i.quote_char) begin
              step_o.keep         = 1'b1;
              step_o.res.out_byte = ch_i;
            end else begin
              st_d.body_err = qsu_pkg::ST_BAD_ESCAPE;
            end
            if (step_o.keep) begin
              st_d.phase = qsu_pkg::PH_NORMAL;
            end
          end
          qsu_pkg::PH_HEX1: begin
            st_d.high_ok     = hx.ok;
            st_d.high_nibble = hx.val;
            st_d.phase       = qsu_pkg::PH_HEX2;
          end
          qsu_pkg::PH_HEX2: begin
            if (hx.ok && st_q.high_ok) begin
              step_o.keep         = 1'b1;
              step_o.res.out_byte = {st_q.high_nibble, hx.val};
              st_d.phase          = qsu_pkg::PH_NORMAL;
            end else begin
              st_d.body_err = qsu_pkg::ST_BAD_HEX;
            end
          end
          default: begin
            st_d.phase = qsu_pkg::PH_NORMAL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= qsu_pkg::LIT_STATE_RESET;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

`ifndef SYNTHESIS
  a_hdr_err_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.hdr_err == qsu_pkg::ST_OK || st_q.hdr_err == qsu_pkg::ST_RAW_PREFIX ||
    st_q.hdr_err == qsu_pkg::ST_DELIM)
    else $error("header error holds a body code");

  a_body_err_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.body_err == qsu_pkg::ST_OK || st_q.body_err == qsu_pkg::ST_CONTROL ||
    st_q.body_err == qsu_pkg::ST_BAD_ESCAPE || st_q.body_err == qsu_pkg::ST_BAD_HEX)
    else $error("body error holds a header code");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last_i |=> st_q == qsu_pkg::LIT_STATE_RESET)
    else $error("literal state not cleared after end word");
`endif

endmodule

// ----- src/qsu_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_out_stage
// Result register of the master-side stream; frees itself when the word is
// taken and reloads in the same cycle.
// ----------------------------------------------------------------------------
module qsu_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  qsu_pkg::result_t  res_i,
  input  logic              tready_i,
  output logic              can_take_o,
  output logic              tvalid_o,
  output qsu_pkg::result_t  res_o
);

  logic             valid_q, valid_d;
  qsu_pkg::result_t res_q;

  assign can_take_o = !valid_q || tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign tvalid_o = valid_q;
  assign res_o    = res_q;

endmodule

// ----- src/quoted_string_unescaper_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescaper_unit
// Decodes a quoted literal streamed one character per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character of the literal per word in tdata, delimiters
//   included; tlast flags the closing character. m_axis returns one word per
//   kept body byte (tlast low, status zero) and one end word on tlast
//   (out_byte zero, status in tdata[10:8]). Characters that are consumed
//   without output (prefix, quotes, backslash, x, first hex digit) give no word.
//   The cfg port sets quote char (index 0) and raw mode (index 1); write it
//   only while no literal is in flight.
// Timing:
//   one character per cycle sustained while m_axis accepts; a character is
//   captured in the input register, and its word is offered on m_axis from
//   the result register, which loads when the input register advances. The
//   decode step is combinational logic between those two registers.
// Reset:
//   both stages empty, literal state cleared, quote char 0x22, raw mode off.
// Stall:
//   a held m_axis word keeps the result register; the input register still
//   fills, and s_axis_tready drops only when both are occupied.
// ----------------------------------------------------------------------------
module quoted_string_unescaper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, zero fill
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i
);

  qsu_pkg::cfg_t      cfg_q;
  logic               in_valid_q;
  logic [7:0]         in_ch_q;
  logic               in_last_q;
  logic               advance;
  logic               out_can_take;
  qsu_pkg::step_out_t step;
  qsu_pkg::result_t   out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quote_char <= qsu_pkg::QUOTE_RESET;
      cfg_q.raw_mode   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        qsu_pkg::REG_QUOTE_CHAR: cfg_q.quote_char <= cfg_wdata_i;
        qsu_pkg::REG_RAW_MODE:   cfg_q.raw_mode   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register moves on when the result register can take its word
  assign advance       = in_valid_q && out_can_take;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  qsu_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cfg_i     (cfg_q),
    .ch_i      (in_ch_q),
    .last_i    (in_last_q),
    .step_o    (step)
  );

  qsu_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && step.keep),
    .res_i      (step.res),
    .tready_i   (m_axis_tready),
    .can_take_o (out_can_take),
    .tvalid_o   (m_axis_tvalid),
    .res_o      (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.status, out_res.out_byte};
  assign m_axis_tlast = out_res.is_end;

endmodule

// ----- tb/quoted_string_unescaper_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescaper_unit_tb
// Self-checking testbench for the quoted string unescaper. Feeds a short
// table of hand-picked literals and then random literals under several
// quote/raw settings. A behavioral decoder or a typed table row predicts
// each output word; it is compared field by field in arrival order. Both
// stream sides idle at random; one phase holds the output off for a long
// stretch.
// ----------------------------------------------------------------------------
module quoted_string_unescaper_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned TAB_SIZE = 40;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned CHARS_PER_PHASE = 210;

  typedef enum logic {ROW_CHAR, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic              addr;
    logic [7:0]        data;
    logic              last;
    logic              typed;
    qsu_pkg::result_t  want;
  } tab_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] ch
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [10:8] status, zero fill
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = qsu_pkg::REG_QUOTE_CHAR;
  logic [7:0]  cfg_wdata_i = 8'h00;

  quoted_string_unescaper_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // decoder model state
  logic [7:0]       quote_q = qsu_pkg::QUOTE_RESET;
  logic             raw_q = 1'b0;
  logic [1:0]       lit_pos = 2'd0;
  qsu_pkg::phase_e  esc_phase = qsu_pkg::PH_NORMAL;
  logic [3:0]       hex_hi = 4'd0;
  logic             hex_hi_ok = 1'b0;
  qsu_pkg::status_e hdr_status = qsu_pkg::ST_OK;
  qsu_pkg::status_e body_status = qsu_pkg::ST_OK;

  qsu_pkg::result_t pending_words[$];
  int unsigned      err_count = 0;
  int unsigned      chars_sent = 0;
  bit               gaps_on = 1'b1;
  bit               hold_off_req = 1'b0;

  tab_row_t    dir_tab[TAB_SIZE];
  int unsigned n_rows = 0;

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // {ok, value} of one hex digit character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b1, 4'(c[3:0] + 4'd9)};
    return 5'd0;
  endfunction

  // advances the model by one character; returns 1 when a word comes out
  function automatic logic decode_char(input logic [7:0] c, input logic l,
                                       output qsu_pkg::result_t r);
    logic [1:0] hdr_len;
    logic [1:0] seen;
    logic [4:0] hv;
    logic       keep;
    hdr_len = raw_q ? 2'd2 : 2'd1;
    seen = lit_pos;
    keep = 1'b0;
    r.out_byte = 8'h00;
    r.is_end = 1'b0;
    r.status = qsu_pkg::ST_OK;
    if (l) begin
      r.is_end = 1'b1;
      if (lit_pos < hdr_len) r.status = qsu_pkg::ST_SHORT;
      else if (hdr_status != qsu_pkg::ST_OK) r.status = hdr_status;
      else if (c != quote_q) r.status = qsu_pkg::ST_DELIM;
      else if (body_status != qsu_pkg::ST_OK) r.status = body_status;
      else if (esc_phase != qsu_pkg::PH_NORMAL) r.status = qsu_pkg::ST_INCOMPLETE;
      lit_pos = 2'd0;
      esc_phase = qsu_pkg::PH_NORMAL;
      hex_hi = 4'd0;
      hex_hi_ok = 1'b0;
      hdr_status = qsu_pkg::ST_OK;
      body_status = qsu_pkg::ST_OK;
      return 1'b1;
    end
    if (lit_pos != 2'd3) lit_pos = lit_pos + 2'd1;
    if (seen < hdr_len) begin
      if (raw_q && seen == 2'd0) begin
        if (c != qsu_pkg::CH_R_LOW && c != qsu_pkg::CH_R_UP &&
            hdr_status == qsu_pkg::ST_OK) hdr_status = qsu_pkg::ST_RAW_PREFIX;
      end else if (c != quote_q && hdr_status == qsu_pkg::ST_OK) begin
        hdr_status = qsu_pkg::ST_DELIM;
      end
      return 1'b0;
    end
    // any recorded error swallows the rest of the body
    if (hdr_status != qsu_pkg::ST_OK || body_status != qsu_pkg::ST_OK) return 1'b0;
    case (esc_phase)
      qsu_pkg::PH_NORMAL: begin
        if (c < qsu_pkg::CH_SPACE || c == qsu_pkg::CH_DEL) body_status = qsu_pkg::ST_CONTROL;
        else if (!raw_q && c == qsu_pkg::CH_BACKSLASH) esc_phase = qsu_pkg::PH_ESCAPE;
        else begin
          r.out_byte = c;
          keep = 1'b1;
        end
      end
      qsu_pkg::PH_ESCAPE: begin
        keep = 1'b1;
        // escape letters win over a quote char that equals one of them
        if (c == qsu_pkg::CH_BACKSLASH) r.out_byte = qsu_pkg::CH_BACKSLASH;
        else if (c == qsu_pkg::CH_N) r.out_byte = qsu_pkg::BYTE_LF;
        else if (c == qsu_pkg::CH_R_LOW) r.out_byte = qsu_pkg::BYTE_CR;
        else if (c == qsu_pkg::CH_T) r.out_byte = qsu_pkg::BYTE_TAB;
        else if (c == qsu_pkg::CH_X) begin
          keep = 1'b0;
          esc_phase = qsu_pkg::PH_HEX1;
        end else if (c == quote_q) r.out_byte = c;
        else begin
          keep = 1'b0;
          body_status = qsu_pkg::ST_BAD_ESCAPE;
        end
        if (keep) esc_phase = qsu_pkg::PH_NORMAL;
      end
      qsu_pkg::PH_HEX1: begin
        hv = hex_value(c);
        hex_hi_ok = hv[4];
        hex_hi = hv[3:0];
        esc_phase = qsu_pkg::PH_HEX2;
      end
      default: begin
        hv = hex_value(c);
        if (hv[4] && hex_hi_ok) begin
          r.out_byte = {hex_hi, hv[3:0]};
          keep = 1'b1;
          esc_phase = qsu_pkg::PH_NORMAL;
        end else begin
          body_status = qsu_pkg::ST_BAD_HEX;
        end
      end
    endcase
    return keep;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 4) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // a hex digit in either case, rarely any byte at all
  function automatic logic [7:0] hex_char();
    logic [3:0] v;
    v = 4'($urandom);
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  task automatic row_char(input logic [7:0] c, input logic l);
    dir_tab[n_rows] = '{ROW_CHAR, qsu_pkg::REG_QUOTE_CHAR, c, l, 1'b0,
                        qsu_pkg::result_t'(0)};
    n_rows++;
  endtask

  task automatic row_want(input logic [7:0] c, input logic l, input logic [7:0] b,
                          input logic e, input qsu_pkg::status_e st);
    qsu_pkg::result_t w;
    w.out_byte = b;
    w.is_end = e;
    w.status = st;
    dir_tab[n_rows] = '{ROW_CHAR, qsu_pkg::REG_QUOTE_CHAR, c, l, 1'b1, w};
    n_rows++;
  endtask

  task automatic row_reg(input logic a, input logic [7:0] v);
    dir_tab[n_rows] = '{ROW_REG, a, v, 1'b0, 1'b0, qsu_pkg::result_t'(0)};
    n_rows++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic l, input logic typed,
                           input qsu_pkg::result_t want);
    int unsigned      gap;
    qsu_pkg::result_t got;
    gap = (gaps_on && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= l;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    chars_sent++;
    if (decode_char(c, l, got) && !typed) pending_words.push_back(got);
    if (typed) pending_words.push_back(want);
  endtask

  // block idle: nothing owed and the pipeline flushed
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic a, input logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= a;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    if (a == qsu_pkg::REG_QUOTE_CHAR) quote_q = v;
    else raw_q = v[0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_literal();
    int unsigned body_len;
    int unsigned sel;
    logic [7:0]  c;
    if (raw_q) begin
      sel = $urandom_range(0, 19);
      c = (sel == 0) ? 8'($urandom) : (sel < 10 ? qsu_pkg::CH_R_LOW : qsu_pkg::CH_R_UP);
      send_char(c, 1'b0, 1'b0, '0);
    end
    // occasionally close right away, too short in either mode
    if ($urandom_range(0, 24) == 0) begin
      send_char(quote_q, 1'b1, 1'b0, '0);
      return;
    end
    send_char(($urandom_range(0, 19) == 0) ? 8'($urandom) : quote_q, 1'b0, 1'b0, '0);
    body_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
    repeat (body_len) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_char(8'($urandom_range(32, 126)), 1'b0, 1'b0, '0);
      end else if (sel < 60) begin
        send_char(8'($urandom_range(128, 255)), 1'b0, 1'b0, '0);
      end else if (sel < 90) begin
        send_char(qsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, '0);
        sel = $urandom_range(0, 19);
        if (sel < 3) send_char(qsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, '0);
        else if (sel < 6) send_char(qsu_pkg::CH_N, 1'b0, 1'b0, '0);
        else if (sel < 9) send_char(qsu_pkg::CH_R_LOW, 1'b0, 1'b0, '0);
        else if (sel < 12) send_char(qsu_pkg::CH_T, 1'b0, 1'b0, '0);
        else if (sel < 14) send_char(quote_q, 1'b0, 1'b0, '0);
        else if (sel < 18) begin
          send_char(qsu_pkg::CH_X, 1'b0, 1'b0, '0);
          send_char(hex_char(), 1'b0, 1'b0, '0);
          if ($urandom_range(0, 9) != 0) send_char(hex_char(), 1'b0, 1'b0, '0);
        end else send_char(8'($urandom), 1'b0, 1'b0, '0);
      end else if (sel < 95) begin
        c = ($urandom_range(0, 4) == 0) ? qsu_pkg::CH_DEL : 8'($urandom_range(0, 31));
        send_char(c, 1'b0, 1'b0, '0);
      end else begin
        send_char(8'($urandom), 1'b0, 1'b0, '0);
      end
    end
    send_char(($urandom_range(0, 19) == 0) ? 8'($urandom) : quote_q, 1'b1, 1'b0, '0);
  endtask

  // output side: checks each accepted word, then picks the next tready
  initial begin : sink
    int unsigned      stall_left;
    qsu_pkg::result_t exp_w;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word, got byte %02h end %0b status %0d", $time,
                   m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[10:8]);
          err_count++;
        end else begin
          exp_w = pending_words.pop_front();
          if (exp_w.out_byte !== m_axis_tdata[7:0] || exp_w.is_end !== m_axis_tlast ||
              exp_w.status !== m_axis_tdata[10:8]) begin
            $display({"%0t: mismatch, expected byte %02h end %0b status %0d,",
                      " got byte %02h end %0b status %0d"},
                     $time, exp_w.out_byte, exp_w.is_end, exp_w.status,
                     m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[10:8]);
            err_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] quote_plan[N_PHASES];
    logic       raw_plan[N_PHASES];
    int unsigned ph;
    int unsigned phase_end;
    quote_plan = '{8'h22, 8'h00, 8'hFF, 8'h6E, 8'h27, 8'h5C, 8'h00, 8'h22};
    raw_plan = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    quote_plan[6] = 8'($urandom);
    raw_plan[6] = 1'($urandom);

    // directed literals, default quote and raw mode off
    row_want(8'h22, 1'b1, 8'h00, 1'b1, qsu_pkg::ST_SHORT);
    row_char(8'h22, 1'b0);
    row_want(8'hFF, 1'b0, 8'hFF, 1'b0, qsu_pkg::ST_OK);
    row_char(qsu_pkg::CH_BACKSLASH, 1'b0);
    row_char(qsu_pkg::CH_X, 1'b0);
    row_char(8'h61, 1'b0);
    row_char(8'h46, 1'b0);
    row_want(8'h22, 1'b1, 8'h00, 1'b1, qsu_pkg::ST_OK);
    row_char(8'h22, 1'b0);
    row_char(8'h00, 1'b0);
    row_want(8'h22, 1'b1, 8'h00, 1'b1, qsu_pkg::ST_CONTROL);
    row_char(8'h27, 1'b0);
    row_want(8'h22, 1'b1, 8'h00, 1'b1, qsu_pkg::ST_DELIM);
    row_char(8'h22, 1'b0);
    row_char(qsu_pkg::CH_BACKSLASH, 1'b0);
    row_char(8'h71, 1'b0);
    row_want(8'h22, 1'b1, 8'h00, 1'b1, qsu_pkg::ST_BAD_ESCAPE);
    row_char(8'h22, 1'b0);
    row_char(qsu_pkg::CH_BACKSLASH, 1'b0);
    row_char(qsu_pkg::CH_X, 1'b0);
    row_char(8'h67, 1'b0);
    row_char(8'h30, 1'b0);
    row_want(8'h22, 1'b1, 8'h00, 1'b1, qsu_pkg::ST_BAD_HEX);
    row_char(8'h22, 1'b0);
    row_char(qsu_pkg::CH_BACKSLASH, 1'b0);
    row_want(8'h22, 1'b1, 8'h00, 1'b1, qsu_pkg::ST_INCOMPLETE);
    // raw mode: prefix required, backslash is a plain byte
    row_reg(qsu_pkg::REG_RAW_MODE, 8'h01);
    row_char(qsu_pkg::CH_R_UP, 1'b0);
    row_char(8'h22, 1'b0);
    row_char(qsu_pkg::CH_BACKSLASH, 1'b0);
    row_want(8'h22, 1'b1, 8'h00, 1'b1, qsu_pkg::ST_OK);
    row_char(8'h41, 1'b0);
    row_char(8'h22, 1'b0);
    row_want(8'h22, 1'b1, 8'h00, 1'b1, qsu_pkg::ST_RAW_PREFIX);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < n_rows; i++) begin
      if (dir_tab[i].kind == ROW_REG) begin
        drain();
        write_reg(dir_tab[i].addr, dir_tab[i].data);
      end else begin
        send_char(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      // sender waits for every owed word before reconfiguring
      drain();
      write_reg(qsu_pkg::REG_QUOTE_CHAR, quote_plan[ph]);
      write_reg(qsu_pkg::REG_RAW_MODE, {7'd0, raw_plan[ph]});
      gaps_on = (ph != 1);
      if (ph == 2) hold_off_req = 1'b1;
      phase_end = chars_sent + CHARS_PER_PHASE;
      while (chars_sent < phase_end) begin
        if ($urandom_range(0, 99) < 85) begin
          send_literal();
        end else begin
          repeat ($urandom_range(1, 6))
            send_char(8'($urandom), $urandom_range(0, 5) == 0, 1'b0, '0);
        end
      end
    end

    drain();
    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
src/qsu_pkg.sv
src/qsu_core.sv
src/qsu_out_stage.sv
src/quoted_string_unescaper_unit.sv
tb/quoted_string_unescaper_unit_tb.sv
